### hw/rtl/lfgp_pkg.sv
// ----------------------------------------------------------------------------
// Lowest free gap placer package
// Shared field widths, command and status codes, defaults and control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfgp_pkg;

	// Default table depth and coordinate width.
	localparam int DEF_MAX_BLOCKS = 256;
	localparam int DEF_COORD_BITS = 16;

	// Fixed widths of the item fields.
	localparam int FUNC_W = 2;
	localparam int XS_W   = 15;
	localparam int XE_W   = 16;
	localparam int H_W    = 15;
	localparam int YF_W   = 15;
	localparam int YP_W   = 16;
	localparam int ST_W   = 2;

	// Command codes carried in func.
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIXED = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd2;

	// Result status codes.
	localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [ST_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [ST_W-1:0] STATUS_OVERFLOW = 2'd2;

	// Control from the sequencer to the gap search unit.
	typedef struct packed {
		logic first;   // first entry of the walk, no open group yet
		logic flush;   // close the open group without taking a new entry
		logic any;     // the open group has at least one overlapping entry
	} grp_ctl_t;

	// Status from the gap search unit back to the sequencer.
	typedef struct packed {
		logic stop;    // the block fits below the group just closed
		logic any;     // next value of the open-group overlap flag
	} grp_res_t;

endpackage : lfgp_pkg

`default_nettype wire

### hw/rtl/lfgp_ram.sv
// ----------------------------------------------------------------------------
// Lowest free gap placer RAM
// Generic simple dual port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfgp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule : lfgp_ram

`default_nettype wire

### hw/rtl/lfgp_unit.sv
// ----------------------------------------------------------------------------
// Lowest free gap placer search unit
// Folds one stored rectangle per cycle into the running gap search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfgp_unit #(
	parameter int COORD_BITS = lfgp_pkg::DEF_COORD_BITS
) (
	input  wire lfgp_pkg::grp_ctl_t                          ctl,
	input  wire logic [lfgp_pkg::XS_W-1:0]                   x_start,
	input  wire logic [lfgp_pkg::XE_W-1:0]                   x_end,
	input  wire logic [lfgp_pkg::H_W-1:0]                    height,
	input  wire logic [COORD_BITS-1:0]                       e_left,
	input  wire logic [COORD_BITS-1:0]                       e_right,
	input  wire logic [COORD_BITS-1:0]                       e_bottom,
	input  wire logic [COORD_BITS-1:0]                       e_top,
	input  wire logic [((COORD_BITS > 15) ? COORD_BITS : 15)-1:0] y,
	input  wire logic [COORD_BITS-1:0]                       cur_b,
	input  wire logic [COORD_BITS-1:0]                       grp_top,
	output logic      [((COORD_BITS > 15) ? COORD_BITS : 15)-1:0] y_next,
	output logic      [COORD_BITS-1:0]                       cur_b_next,
	output logic      [COORD_BITS-1:0]                       grp_top_next,
	output lfgp_pkg::grp_res_t                               res
);

	localparam int YW   = (COORD_BITS > 15) ? COORD_BITS : 15;
	localparam int WIDE = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

	logic            hit;
	logic [WIDE-1:0] lim;
	logic            new_group;
	logic            close;
	logic            fits;
	logic            any_next;

	// Horizontal overlap of the stored entry with the new block.
	assign hit = (WIDE'(x_start) < WIDE'(e_right)) && (WIDE'(x_end) > WIDE'(e_left));

	// The open group is closed when the bottom changes or the walk ends.
	assign lim       = WIDE'(y) + WIDE'(height);
	assign new_group = ctl.first || ctl.flush || (e_bottom != cur_b);
	assign close     = new_group && ctl.any;
	assign fits      = WIDE'(cur_b) >= lim;
	assign res.stop  = close && fits;
	assign res.any   = any_next;

	// A closed group that blocks the block lifts y to its highest top.
	always_comb begin
		y_next = y;
		if (close && !fits && (YW'(grp_top) > y)) begin
			y_next = YW'(grp_top);
		end
	end

	// Open a new group or extend the current one with this entry.
	always_comb begin
		cur_b_next   = cur_b;
		grp_top_next = grp_top;
		any_next     = ctl.any;
		priority if (ctl.flush) begin
			any_next = 1'b0;
		end else if (new_group) begin
			cur_b_next   = e_bottom;
			grp_top_next = e_top;
			any_next     = hit;
		end else begin
			if (hit) begin
				any_next = 1'b1;
				if (!ctl.any || (e_top > grp_top)) begin
					grp_top_next = e_top;
				end
			end
		end
	end

endmodule : lfgp_unit

`default_nettype wire

### hw/rtl/lowest_free_gap_placer_core.sv
// Clear goes straight to the result. Fixed and place items go to the result from the decision
// step when refused or when the table is empty, else after the entries above the new bottom
// are shifted up; a place item first reads the entries one by one in the gap search, stopping
// where the block fits and closing the last group when it reaches the table end.
// One item is in work at a time; in_ready returns with out_valid once the result is loaded.
// Reset empties the table (entry count zero); the table RAM itself is not cleared.
// ----------------------------------------------------------------------------
// Lowest free gap placer core
// Keeps placed rectangles sorted by bottom y and places new blocks in the lowest gap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_gap_placer_core #(
	parameter int MAX_BLOCKS = lfgp_pkg::DEF_MAX_BLOCKS,
	parameter int COORD_BITS = lfgp_pkg::DEF_COORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lfgp_pkg::FUNC_W-1:0]   func,
	input  wire logic [lfgp_pkg::XS_W-1:0]     x_start,
	input  wire logic [lfgp_pkg::XE_W-1:0]     x_end,
	input  wire logic [lfgp_pkg::H_W-1:0]      height,
	input  wire logic [lfgp_pkg::YF_W-1:0]     y_fixed,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [lfgp_pkg::YP_W-1:0]     place_y,
	output logic      [lfgp_pkg::ST_W-1:0]     status
);

	localparam int AW   = $clog2(MAX_BLOCKS);
	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int YW   = (COORD_BITS > 15) ? COORD_BITS : 15;
	localparam int WIDE = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
	localparam int EW   = 4 * COORD_BITS;
	localparam logic [WIDE-1:0] CMAX = WIDE'((65'd1 << COORD_BITS) - 65'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL,
		ST_DECIDE,
		ST_INS,
		ST_INS_LAST,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   ptr_q;
	logic [lfgp_pkg::XS_W-1:0]       xs_q;
	logic [lfgp_pkg::XE_W-1:0]       xe_q;
	logic [lfgp_pkg::H_W-1:0]        h_q;
	logic [YW-1:0]                   y_q;
	logic [COORD_BITS-1:0]           cur_b_q;
	logic [COORD_BITS-1:0]           grp_top_q;
	logic                            any_q;
	logic                            first_q;
	logic [lfgp_pkg::ST_W-1:0]       res_st_q;
	logic                            out_valid_q;
	logic [lfgp_pkg::YP_W-1:0]       place_y_q;
	logic [lfgp_pkg::ST_W-1:0]       status_q;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [EW-1:0]                   ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [EW-1:0]                   ram_rdata;

	logic [COORD_BITS-1:0]           rd_left;
	logic [COORD_BITS-1:0]           rd_right;
	logic [COORD_BITS-1:0]           rd_bottom;
	logic [COORD_BITS-1:0]           rd_top;

	lfgp_pkg::grp_ctl_t              ctl;
	lfgp_pkg::grp_res_t              res;
	logic [YW-1:0]                   y_next;
	logic [COORD_BITS-1:0]           cur_b_next;
	logic [COORD_BITS-1:0]           grp_top_next;

	logic [CW-1:0]                   cnt_m1;
	logic                            full;
	logic [WIDE-1:0]                 top_w;
	logic                            ovf;
	logic                            shift;
	logic [EW-1:0]                   new_entry;

	// Table storage: left, right, bottom and top packed in one word.
	lfgp_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_BLOCKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_left   = ram_rdata[4*COORD_BITS-1:3*COORD_BITS];
	assign rd_right  = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
	assign rd_bottom = ram_rdata[2*COORD_BITS-1:COORD_BITS];
	assign rd_top    = ram_rdata[COORD_BITS-1:0];

	// Gap search unit, one entry per cycle.
	assign ctl.first = first_q;
	assign ctl.flush = (state_q == ST_FINAL);
	assign ctl.any   = any_q;

	lfgp_unit #(
		.COORD_BITS(COORD_BITS)
	) u_unit (
		.ctl         (ctl),
		.x_start     (xs_q),
		.x_end       (xe_q),
		.height      (h_q),
		.e_left      (rd_left),
		.e_right     (rd_right),
		.e_bottom    (rd_bottom),
		.e_top       (rd_top),
		.y           (y_q),
		.cur_b       (cur_b_q),
		.grp_top     (grp_top_q),
		.y_next      (y_next),
		.cur_b_next  (cur_b_next),
		.grp_top_next(grp_top_next),
		.res         (res)
	);

	// Record checks and the new table entry.
	assign cnt_m1    = count_q - CW'(1);
	assign full      = (count_q == CW'(MAX_BLOCKS));
	assign top_w     = WIDE'(y_q) + WIDE'(h_q);
	assign ovf       = (WIDE'(xs_q) > CMAX) || (WIDE'(xe_q) > CMAX) ||
	                   (WIDE'(y_q) > CMAX) || (top_w > CMAX);
	assign shift     = WIDE'(rd_bottom) > WIDE'(y_q);
	assign new_entry = {COORD_BITS'(xs_q), COORD_BITS'(xe_q), COORD_BITS'(y_q),
	                    COORD_BITS'(top_w)};

	// RAM read address follows the walk direction of the current phase.
	always_comb begin
		unique case (state_q)
			ST_IDLE:   ram_raddr = '0;
			ST_SCAN:   ram_raddr = ptr_q + AW'(1);
			ST_DECIDE: ram_raddr = cnt_m1[AW-1:0];
			ST_INS:    ram_raddr = ptr_q - AW'(1);
			default:   ram_raddr = ptr_q;
		endcase
	end

	// RAM writes: shift entries up one place, then drop in the new block; an empty table takes it at address zero.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = new_entry;
		unique case (state_q)
			ST_DECIDE: begin
				ram_we = !full && !ovf && (count_q == '0);
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + AW'(1);
				ram_wdata = shift ? ram_rdata : new_entry;
			end
			ST_INS_LAST: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						xs_q      <= x_start;
						xe_q      <= x_end;
						h_q       <= height;
						y_q       <= (func == lfgp_pkg::FUNC_FIXED) ? YW'(y_fixed) : '0;
						any_q     <= 1'b0;
						first_q   <= 1'b1;
						ptr_q     <= '0;
						res_st_q  <= lfgp_pkg::STATUS_OK;
						unique case (func)
							lfgp_pkg::FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESULT;
							end
							lfgp_pkg::FUNC_FIXED: begin
								state_q <= ST_DECIDE;
							end
							lfgp_pkg::FUNC_PLACE: begin
								state_q <= (count_q == '0) ? ST_DECIDE : ST_SCAN;
							end
							default: begin
								state_q <= ST_RESULT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					priority if (res.stop) begin
						state_q <= ST_DECIDE;
					end else begin
						y_q       <= y_next;
						cur_b_q   <= cur_b_next;
						grp_top_q <= grp_top_next;
						any_q     <= res.any;
						first_q   <= 1'b0;
						if (ptr_q == cnt_m1[AW-1:0]) begin
							state_q <= ST_FINAL;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				ST_FINAL: begin
					y_q     <= y_next;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					priority if (full) begin
						res_st_q <= lfgp_pkg::STATUS_FULL;
						state_q  <= ST_RESULT;
					end else if (ovf) begin
						res_st_q <= lfgp_pkg::STATUS_OVERFLOW;
						state_q  <= ST_RESULT;
					end else if (count_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESULT;
					end else begin
						ptr_q   <= cnt_m1[AW-1:0];
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					priority if (!shift) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_RESULT;
					end else if (ptr_q == '0) begin
						state_q <= ST_INS_LAST;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				ST_INS_LAST: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						place_y_q   <= lfgp_pkg::YP_W'(y_q);
						status_q    <= res_st_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign place_y   = place_y_q;
	assign status    = status_q;

endmodule : lowest_free_gap_placer_core

`default_nettype wire

### sim/lowest_free_gap_placer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free gap placer core testbench
// Sends clear, fixed, place and unused-code items through the valid/ready input
// and checks every result against a built-in model of the span table. A short
// directed list covers gap fits, equal bottoms, odd shapes and coordinate
// overflow. The random part runs short placement bursts and fills the table to
// its limit twice. Both sides idle in random bursts until the final stretch.
// ----------------------------------------------------------------------------

module lowest_free_gap_placer_core_test;

	localparam int TABLE_DEPTH = lfgp_pkg::DEF_MAX_BLOCKS;
	localparam int unsigned COORD_MAX = (1 << lfgp_pkg::DEF_COORD_BITS) - 1;
	localparam logic [lfgp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 830;
	localparam int CALM_TAIL = 60;
	localparam int SETTLE_CYCLES = 600;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [lfgp_pkg::FUNC_W-1:0] func;
		logic [lfgp_pkg::XS_W-1:0]   xs;
		logic [lfgp_pkg::XE_W-1:0]   xe;
		logic [lfgp_pkg::H_W-1:0]    h;
		logic [lfgp_pkg::YF_W-1:0]   yf;
		bit                          drain;
	} placer_cmd_t;

	typedef struct {
		logic [lfgp_pkg::YP_W-1:0] y;
		logic [lfgp_pkg::ST_W-1:0] st;
	} placement_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [lfgp_pkg::FUNC_W-1:0] func = lfgp_pkg::FUNC_CLEAR;
	logic [lfgp_pkg::XS_W-1:0] x_start = '0;
	logic [lfgp_pkg::XE_W-1:0] x_end = '0;
	logic [lfgp_pkg::H_W-1:0] height = '0;
	logic [lfgp_pkg::YF_W-1:0] y_fixed = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [lfgp_pkg::YP_W-1:0] place_y;
	logic [lfgp_pkg::ST_W-1:0] status;

	// Items waiting to be sent and placements waiting to come back.
	placer_cmd_t cmd_queue[$];
	placement_t placements_due[$];

	// Model copy of the span table.
	int unsigned span_lo[TABLE_DEPTH];
	int unsigned span_hi[TABLE_DEPTH];
	int unsigned span_bot[TABLE_DEPTH];
	int unsigned span_top[TABLE_DEPTH];
	int unsigned span_count = 0;

	int errors = 0;
	int items_taken = 0;
	int results_checked = 0;
	int ok_count = 0;
	int full_count = 0;
	int overflow_count = 0;
	int unsigned deepest_table = 0;
	int cycles = 0;
	int idle_odds = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic cmd_taken = 1'b0;

	lowest_free_gap_placer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.x_start(x_start),
		.x_end(x_end),
		.height(height),
		.y_fixed(y_fixed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.place_y(place_y),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Walk the overlapping spans group by group of equal bottom and return the
	// lowest y at which a block of height h fits.
	function automatic int unsigned lowest_gap_y(int unsigned xs, int unsigned xe,
			int unsigned h);
		int unsigned y;
		int unsigned b;
		int unsigned top_max;
		int unsigned idx;
		bit hit;
		y = 0;
		idx = 0;
		while (idx < span_count) begin
			b = span_bot[idx];
			top_max = 0;
			hit = 1'b0;
			while (idx < span_count && span_bot[idx] == b) begin
				if (xs < span_hi[idx] && xe > span_lo[idx]) begin
					if (!hit || span_top[idx] > top_max)
						top_max = span_top[idx];
					hit = 1'b1;
				end
				idx++;
			end
			if (hit) begin
				if (b >= y + h)
					break;
				if (top_max > y)
					y = top_max;
			end
		end
		return y;
	endfunction

	// Insert a span after all spans with a lower or equal bottom.
	function automatic logic [lfgp_pkg::ST_W-1:0] store_span(int unsigned xs,
			int unsigned xe, int unsigned b, int unsigned h);
		int unsigned t;
		int unsigned pos;
		t = b + h;
		if (span_count >= TABLE_DEPTH)
			return lfgp_pkg::STATUS_FULL;
		if (xs > COORD_MAX || xe > COORD_MAX || b > COORD_MAX || t > COORD_MAX)
			return lfgp_pkg::STATUS_OVERFLOW;
		pos = span_count;
		while (pos > 0 && span_bot[pos-1] > b) begin
			span_lo[pos] = span_lo[pos-1];
			span_hi[pos] = span_hi[pos-1];
			span_bot[pos] = span_bot[pos-1];
			span_top[pos] = span_top[pos-1];
			pos--;
		end
		span_lo[pos] = xs;
		span_hi[pos] = xe;
		span_bot[pos] = b;
		span_top[pos] = t;
		span_count++;
		return lfgp_pkg::STATUS_OK;
	endfunction

	// Apply one accepted item to the model and return the placement it yields.
	function automatic placement_t predict_placement(logic [lfgp_pkg::FUNC_W-1:0] f,
			logic [lfgp_pkg::XS_W-1:0] xs, logic [lfgp_pkg::XE_W-1:0] xe,
			logic [lfgp_pkg::H_W-1:0] h, logic [lfgp_pkg::YF_W-1:0] yf);
		placement_t r;
		int unsigned y;
		r.y = '0;
		r.st = lfgp_pkg::STATUS_OK;
		case (f)
			lfgp_pkg::FUNC_CLEAR: begin
				span_count = 0;
			end
			lfgp_pkg::FUNC_FIXED: begin
				r.y = yf;
				r.st = store_span(xs, xe, yf, h);
			end
			lfgp_pkg::FUNC_PLACE: begin
				y = lowest_gap_y(xs, xe, h);
				r.y = y[lfgp_pkg::YP_W-1:0];
				r.st = store_span(xs, xe, y, h);
			end
			default: begin
			end
		endcase
		if (span_count > deepest_table)
			deepest_table = span_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("MISMATCH at result %0d: %s expected %0d, got %0d", results_checked, what,
			want, got);
		errors++;
	endtask

	task automatic queue_cmd(input logic [lfgp_pkg::FUNC_W-1:0] f, input int unsigned xs,
			input int unsigned xe, input int unsigned h, input int unsigned yf,
			input bit drain);
		placer_cmd_t c;
		c.func = f;
		c.xs = xs[lfgp_pkg::XS_W-1:0];
		c.xe = xe[lfgp_pkg::XE_W-1:0];
		c.h = h[lfgp_pkg::H_W-1:0];
		c.yf = yf[lfgp_pkg::YF_W-1:0];
		c.drain = drain;
		cmd_queue = {cmd_queue, c};
	endtask

	// Mostly placements in a narrow x window so spans stack up; some items use
	// the full field ranges, odd shapes, stray clears or the unused code.
	task automatic queue_random_cmd(input bit records_only);
		int unsigned pick;
		int unsigned xs;
		int unsigned xe;
		int unsigned h;
		int unsigned yf;
		logic [lfgp_pkg::FUNC_W-1:0] f;
		pick = $urandom_range(0, 99);
		if (records_only)
			f = (pick < 75) ? lfgp_pkg::FUNC_PLACE : lfgp_pkg::FUNC_FIXED;
		else if (pick < 68)
			f = lfgp_pkg::FUNC_PLACE;
		else if (pick < 92)
			f = lfgp_pkg::FUNC_FIXED;
		else if (pick < 96)
			f = FUNC_UNUSED;
		else
			f = lfgp_pkg::FUNC_CLEAR;
		if (!records_only && $urandom_range(0, 9) == 0) begin
			xs = $urandom_range(0, 32767);
			xe = $urandom_range(0, 65535);
			h = $urandom_range(0, 32767);
			yf = $urandom_range(0, 32767);
		end else begin
			xs = $urandom_range(0, 240);
			if ($urandom_range(0, 19) == 0)
				xe = $urandom_range(0, xs);
			else
				xe = xs + $urandom_range(1, 80);
			h = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 40);
			yf = $urandom_range(0, 400);
		end
		queue_cmd(f, xs, xe, h, yf, 1'b0);
	endtask

	// Track which items were taken, then check results and predict new ones.
	always @(posedge clk or negedge arst_n) begin : check_results
		placement_t want;
		placement_t got_next;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (placements_due.size() == 0) begin
					report_mismatch("result with no item pending, place_y", 0, place_y);
				end else begin
					want = placements_due.pop_front();
					if (place_y !== want.y)
						report_mismatch("place_y", want.y, place_y);
					if (status !== want.st)
						report_mismatch("status", want.st, status);
				end
				results_checked++;
			end
			if (in_valid && in_ready) begin
				got_next = predict_placement(func, x_start, x_end, height, y_fixed);
				placements_due = {placements_due, got_next};
				items_taken++;
				case (got_next.st)
					lfgp_pkg::STATUS_FULL: full_count++;
					lfgp_pkg::STATUS_OVERFLOW: overflow_count++;
					default: ok_count++;
				endcase
			end
		end
	end

	// Cycle count, timeout and the idle mix for the next stretch.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 256 == 0)
			idle_odds <= $urandom_range(0, 3);
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Item driver: presents the next queued item once the current one is taken.
	always @(negedge clk) begin : drive_cmds
		placer_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || cmd_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (cmd_queue[0].drain && placements_due.size() != 0) begin
				in_valid <= 1'b0;
			end else if (cmd_queue.size() > CALM_TAIL && idle_odds != 0 &&
					$urandom_range(0, 3 * idle_odds) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 12);
			end else begin
				nxt = cmd_queue.pop_front();
				in_valid <= 1'b1;
				func <= nxt.func;
				x_start <= nxt.xs;
				x_end <= nxt.xe;
				height <= nxt.h;
				y_fixed <= nxt.yf;
			end
		end
	end

	// Result receiver: stalls in random bursts until the final stretch.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else if (cmd_queue.size() > CALM_TAIL && idle_odds != 0 &&
				$urandom_range(0, 3 * idle_odds) == 0) begin
			out_ready <= 1'b0;
			recv_gap <= $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int planned;
		int burst;
		int fills;

		// Directed: unused code, gap fits, equal bottoms, odd shapes, overflow.
		queue_cmd(lfgp_pkg::FUNC_CLEAR, 0, 0, 1, 0, 1'b0);
		queue_cmd(FUNC_UNUSED, 32767, 65535, 32767, 32767, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_FIXED, 0, 10, 10, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_FIXED, 0, 10, 10, 20, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 10, 10, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 10, 11, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_FIXED, 5, 15, 3, 20, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 20, 30, 5, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 10, 10, 4, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 8, 3, 4, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 65535, 0, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_FIXED, 0, 65535, 32767, 32767, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 100, 200, 2, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 100, 200, 1, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 100, 200, 1, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 32767, 65535, 32767, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_FIXED, 32767, 65535, 32767, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_CLEAR, 32767, 65535, 32767, 32767, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 65535, 32767, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 65535, 32767, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_PLACE, 0, 65535, 2, 0, 1'b0);
		queue_cmd(lfgp_pkg::FUNC_CLEAR, 0, 0, 1, 0, 1'b1);

		// Random: short placement bursts, with two runs that fill the table.
		planned = 0;
		fills = 0;
		while (planned < RANDOM_ITEMS) begin
			if ((fills == 0 && planned >= 150) || (fills == 1 && planned >= 520)) begin
				queue_cmd(lfgp_pkg::FUNC_CLEAR, $urandom_range(0, 32767),
					$urandom_range(0, 65535), $urandom_range(0, 32767),
					$urandom_range(0, 32767), fills == 1);
				repeat (TABLE_DEPTH) queue_random_cmd(1'b1);
				repeat (12) queue_random_cmd(1'b0);
				planned += TABLE_DEPTH + 13;
				fills++;
			end else begin
				burst = $urandom_range(1, 40);
				queue_cmd(lfgp_pkg::FUNC_CLEAR, $urandom_range(0, 32767),
					$urandom_range(0, 65535), $urandom_range(0, 32767),
					$urandom_range(0, 32767), $urandom_range(0, 5) == 0);
				repeat (burst) queue_random_cmd(1'b0);
				planned += burst + 1;
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last item to be taken and its result to come back.
		while (cmd_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (placements_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d results: %0d ok, %0d table full, %0d overflow.",
			items_taken, results_checked, ok_count, full_count, overflow_count);
		$display("Deepest table %0d of %0d entries, %0d cycles, %0d mismatches.",
			deepest_table, TABLE_DEPTH, cycles, errors);
		if (errors == 0 && placements_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lfgp_pkg.sv
hw/rtl/lfgp_ram.sv
hw/rtl/lfgp_unit.sv
hw/rtl/lowest_free_gap_placer_core.sv
sim/lowest_free_gap_placer_core_test.sv
